// File: design/svd_pkg.sv
// Shared types and constants for the speech volume ducker.
// Holds item structs, configuration register codes and reset values.
// No dependencies.
package svd_pkg;

  // Field widths
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned VOL_W     = 7;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned RAMP_W    = 10;
  localparam int unsigned STEP_W    = 7;
  localparam int unsigned FLOOR_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W    = VOL_W + FLOOR_W;

  // Levels at or below this mean the wearer is speaking
  localparam logic [LEVEL_W-1:0] SPEECH_LEVEL_MAX = 8'h02;
  // Full-scale volume in percent
  localparam logic [VOL_W-1:0]   VOL_MAX          = 7'd100;
  // Half an integer LSB of the Q7.16 product, for round half up
  localparam logic [PROD_W-1:0]  ROUND_HALF       = PROD_W'(32768);

  // Register reset values
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST    = 16'd1200;
  localparam logic [RAMP_W-1:0]  RAMP_INTERVAL_RST = 10'd30;
  localparam logic [STEP_W-1:0]  DUCK_STEP_RST     = 7'd9;
  localparam logic [STEP_W-1:0]  RESTORE_STEP_RST  = 7'd2;
  localparam logic [FLOOR_W-1:0] DUCK_FLOOR_RST    = 16'd13107;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_TICKS    = 3'd0,
    CFG_RAMP_INTERVAL = 3'd1,
    CFG_DUCK_STEP     = 3'd2,
    CFG_RESTORE_STEP  = 3'd3,
    CFG_DUCK_FLOOR    = 3'd4
  } cfg_idx_t;

  // Item commands
  localparam logic CMD_LEVEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [HOLD_W-1:0]  hold_ticks;
    logic [RAMP_W-1:0]  ramp_interval_ticks;
    logic [STEP_W-1:0]  duck_step;
    logic [STEP_W-1:0]  restore_step;
    logic [FLOOR_W-1:0] duck_floor_q16;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [LEVEL_W-1:0] level;
    logic               output_is_target;
    logic [VOL_W-1:0]   system_volume;
    logic               system_volume_valid;
  } in_item_t;

  typedef struct packed {
    logic             volume_write;
    logic [VOL_W-1:0] volume;
    logic             ducking_engaged;
  } out_item_t;

endpackage

// File: design/svd_cfg.sv
// Configuration register file of the speech volume ducker.
// Depends on svd_pkg for register codes, widths and reset values.
module svd_cfg import svd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks          <= HOLD_TICKS_RST;
      cfg.ramp_interval_ticks <= RAMP_INTERVAL_RST;
      cfg.duck_step           <= DUCK_STEP_RST;
      cfg.restore_step        <= RESTORE_STEP_RST;
      cfg.duck_floor_q16      <= DUCK_FLOOR_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOLD_TICKS:    cfg.hold_ticks          <= cfg_data[HOLD_W-1:0];
        CFG_RAMP_INTERVAL: cfg.ramp_interval_ticks <= cfg_data[RAMP_W-1:0];
        CFG_DUCK_STEP:     cfg.duck_step           <= cfg_data[STEP_W-1:0];
        CFG_RESTORE_STEP:  cfg.restore_step        <= cfg_data[STEP_W-1:0];
        CFG_DUCK_FLOOR:    cfg.duck_floor_q16      <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/svd_core.sv
// Ducking state and its combinational update for one item, registered when fire is high.
// Depends on svd_pkg for item structs and configuration struct.
module svd_core import svd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic               captured, captured_next;
  logic [VOL_W-1:0]   baseline, baseline_next;
  logic [VOL_W-1:0]   current, current_next;
  logic [VOL_W-1:0]   target, target_next;
  logic               ramp_running, ramp_running_next;
  logic [RAMP_W-1:0]  ramp_counter, ramp_counter_next;
  logic               hold_running, hold_running_next;
  logic [HOLD_W-1:0]  hold_counter, hold_counter_next;

  logic               speech;
  logic [VOL_W-1:0]   capture_vol;
  logic [VOL_W-1:0]   base_sel;
  logic [PROD_W-1:0]  product;
  logic [VOL_W-1:0]   ducked_target;
  logic               hold_expire;
  logic [VOL_W-1:0]   target_mid;
  logic [RAMP_W-1:0]  interval;
  logic [RAMP_W-1:0]  ramp_inc;
  logic [VOL_W-1:0]   down_diff;
  logic [VOL_W:0]     up_sum;
  logic [VOL_W-1:0]   step_vol;
  logic               write;

  // Decode the item and the ducked target
  assign speech        = (item.level <= SPEECH_LEVEL_MAX);
  assign capture_vol   = (item.system_volume > VOL_MAX) ? VOL_MAX : item.system_volume;
  assign base_sel      = captured ? baseline : capture_vol;
  assign product       = PROD_W'(base_sel) * PROD_W'(cfg.duck_floor_q16) + ROUND_HALF;
  assign ducked_target = product[PROD_W-1:FLOOR_W];

  // Hold expiry comes before the ramp on a tick
  assign hold_expire = hold_running && (hold_counter <= HOLD_W'(1));
  assign target_mid  = (hold_expire && captured) ? baseline : target;

  // Ramp timer and one clamped step toward the target
  assign interval  = (cfg.ramp_interval_ticks == '0) ? RAMP_W'(1) : cfg.ramp_interval_ticks;
  assign ramp_inc  = ramp_counter + RAMP_W'(1);
  assign down_diff = current - target_mid;
  assign up_sum    = {1'b0, current} + {1'b0, cfg.restore_step};

  always_comb begin
    if (target_mid < current) begin
      step_vol = (cfg.duck_step >= down_diff) ? target_mid : current - cfg.duck_step;
    end else begin
      step_vol = (up_sum > {1'b0, target_mid}) ? target_mid : up_sum[VOL_W-1:0];
    end
  end

  // Next state for the item in hand
  always_comb begin
    captured_next     = captured;
    baseline_next     = baseline;
    current_next      = current;
    target_next       = target;
    ramp_running_next = ramp_running;
    ramp_counter_next = ramp_counter;
    hold_running_next = hold_running;
    hold_counter_next = hold_counter;
    write             = 1'b0;
    if (item.cmd == CMD_LEVEL) begin
      if (item.output_is_target) begin
        if (speech) begin
          if (captured || item.system_volume_valid) begin
            if (!captured) begin
              baseline_next = capture_vol;
              current_next  = capture_vol;
              captured_next = 1'b1;
            end
            hold_running_next = 1'b0;
            target_next       = ducked_target;
            if (!ramp_running) begin
              ramp_running_next = 1'b1;
              ramp_counter_next = '0;
            end
          end
        end else if (captured) begin
          hold_running_next = 1'b1;
          hold_counter_next = cfg.hold_ticks;
        end
      end
    end else begin
      if (hold_running) begin
        if (hold_expire) begin
          hold_running_next = 1'b0;
          hold_counter_next = '0;
          if (captured) begin
            target_next = baseline;
            if (!ramp_running) begin
              ramp_running_next = 1'b1;
              ramp_counter_next = '0;
            end
          end
        end else begin
          hold_counter_next = hold_counter - HOLD_W'(1);
        end
      end
      // A ramp started on this tick does not advance yet
      if (ramp_running) begin
        ramp_counter_next = ramp_inc;
        if (ramp_inc >= interval) begin
          ramp_counter_next = '0;
          if (!captured) begin
            ramp_running_next = 1'b0;
          end else if (current == target_mid) begin
            ramp_running_next = 1'b0;
            if (target_mid >= baseline) begin
              captured_next = 1'b0;
              baseline_next = '0;
              current_next  = '0;
              target_next   = '0;
            end
          end else begin
            current_next = step_vol;
            write        = 1'b1;
          end
        end
      end
    end
  end

  // Advance state when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      captured     <= 1'b0;
      baseline     <= '0;
      current      <= '0;
      target       <= '0;
      ramp_running <= 1'b0;
      ramp_counter <= '0;
      hold_running <= 1'b0;
      hold_counter <= '0;
    end else if (fire) begin
      captured     <= captured_next;
      baseline     <= baseline_next;
      current      <= current_next;
      target       <= target_next;
      ramp_running <= ramp_running_next;
      ramp_counter <= ramp_counter_next;
      hold_running <= hold_running_next;
      hold_counter <= hold_counter_next;
    end
  end

  assign result.volume_write    = write;
  assign result.volume          = current_next;
  assign result.ducking_engaged = captured_next;

`ifndef ASSERT_OFF
  // The ducked target never exceeds the captured baseline
  a_target_le_base: assert property (@(posedge clk) disable iff (rst)
    captured |-> target <= baseline)
    else $error("target above baseline");

  // Current volume stays within the baseline
  a_cur_le_base: assert property (@(posedge clk) disable iff (rst)
    captured |-> current <= baseline)
    else $error("current volume above baseline");

  // Without a baseline all volume state is cleared
  a_clear_when_free: assert property (@(posedge clk) disable iff (rst)
    !captured |-> (current == '0) && (baseline == '0) && (target == '0))
    else $error("volume state left behind on release");
`endif

endmodule

// File: design/speech_volume_ducker.sv
// Speech volume ducker: lowers volume while the wearer speaks, restores it after a hold.
// Items pass the input register, the combinational update in svd_core and the result register.
// Throughput: one item per cycle while out_ready is high; back-pressure stalls the input register.
// Reset: synchronous active-high rst clears all ducking state and loads register defaults.
// Depends on svd_pkg, svd_cfg and svd_core.
module speech_volume_ducker import svd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  logic      advance;
  out_item_t result;

  svd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move the held item on when the result register is free or draining
  assign advance  = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  svd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // A processed item always lands in the result register
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item lost");

  // A stalled item stays in the input register
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !advance |=> in_q_valid)
    else $error("stalled item dropped");

  // Released results carry zero volume
  a_free_vol_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ducking_engaged |-> out_data.volume == '0)
    else $error("volume reported without baseline");

  // Volume never exceeds full scale
  a_vol_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.volume <= VOL_MAX)
    else $error("volume out of range");
`endif

endmodule

// File: tb/svd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the speech volume ducker: follows register writes and items,
// predicts every result item and compares it with what the block returns.
// Depends on svd_pkg.
module svd_checker import svd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  output int                    fail_count,
  output int                    pending_count
);

  // Shadow copy of the registers and of the ducking state
  cfg_t              regs;
  logic              captured;
  logic [VOL_W-1:0]  base_vol;
  logic [VOL_W-1:0]  cur_vol;
  logic [VOL_W-1:0]  tgt_vol;
  logic              ramp_on;
  logic [RAMP_W-1:0] ramp_cnt;
  logic              hold_on;
  logic [HOLD_W-1:0] hold_cnt;

  out_item_t         due_updates[$];
  out_item_t         due;
  int                errors;

  // Drop the captured baseline and both volumes
  function automatic void clear_volumes();
    captured = 1'b0;
    base_vol = '0;
    cur_vol  = '0;
    tgt_vol  = '0;
  endfunction

  // Start the ramp timer unless it is already running
  function automatic void kick_ramp();
    if (!ramp_on) begin
      ramp_on  = 1'b1;
      ramp_cnt = '0;
    end
  endfunction

  // Baseline scaled by the floor fraction, rounded half up
  function automatic logic [VOL_W-1:0] ducked_target();
    logic [PROD_W:0] prod;
    prod = base_vol * regs.duck_floor_q16 + ROUND_HALF;
    return prod[FLOOR_W +: VOL_W];
  endfunction

  // Move the volume one step towards the target; true when a write is due
  function automatic logic take_ramp_step();
    int cur;
    int tgt;
    int nv;
    if (!captured) begin
      ramp_on = 1'b0;
      return 1'b0;
    end
    cur = int'(cur_vol);
    tgt = int'(tgt_vol);
    if (cur == tgt) begin
      ramp_on = 1'b0;
      if (tgt_vol >= base_vol) clear_volumes();
      return 1'b0;
    end
    if (tgt < cur) begin
      nv = cur - int'(regs.duck_step);
      if (nv < tgt) nv = tgt;
    end else begin
      nv = cur + int'(regs.restore_step);
      if (nv > tgt) nv = tgt;
    end
    cur_vol = nv[VOL_W-1:0];
    return 1'b1;
  endfunction

  // Advance the shadow state by one item and return the result it causes
  function automatic out_item_t duck_update(input in_item_t it);
    out_item_t         res;
    logic              wr;
    logic              ok;
    logic              ramp_was;
    logic [RAMP_W-1:0] step_len;
    wr = 1'b0;
    if (it.cmd == CMD_LEVEL) begin
      if (it.output_is_target) begin
        if (it.level <= SPEECH_LEVEL_MAX) begin
          ok = 1'b1;
          if (!captured) begin
            if (!it.system_volume_valid) begin
              ok = 1'b0;
            end else begin
              base_vol = (it.system_volume > VOL_MAX) ? VOL_MAX : it.system_volume;
              cur_vol  = base_vol;
              captured = 1'b1;
            end
          end
          if (ok) begin
            hold_on = 1'b0;
            tgt_vol = ducked_target();
            kick_ramp();
          end
        end else if (captured) begin
          hold_on  = 1'b1;
          hold_cnt = regs.hold_ticks;
        end
      end
    end else begin
      ramp_was = ramp_on;
      // hold expiry comes before the ramp
      if (hold_on) begin
        if (hold_cnt <= 1) begin
          hold_on  = 1'b0;
          hold_cnt = '0;
          if (captured) begin
            tgt_vol = base_vol;
            kick_ramp();
          end
        end else begin
          hold_cnt = hold_cnt - 1'b1;
        end
      end
      // a ramp started on this tick waits for the next one
      if (ramp_on && ramp_was) begin
        step_len = (regs.ramp_interval_ticks == '0) ? RAMP_W'(1) : regs.ramp_interval_ticks;
        ramp_cnt = ramp_cnt + 1'b1;
        if (ramp_cnt >= step_len) begin
          ramp_cnt = '0;
          wr = take_ramp_step();
        end
      end
    end
    res.volume_write    = wr;
    res.volume          = cur_vol;
    res.ducking_engaged = captured;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = {HOLD_TICKS_RST, RAMP_INTERVAL_RST, DUCK_STEP_RST, RESTORE_STEP_RST,
              DUCK_FLOOR_RST};
      clear_volumes();
      ramp_on  = 1'b0;
      ramp_cnt = '0;
      hold_on  = 1'b0;
      hold_cnt = '0;
      errors   = 0;
      due_updates.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      // Follow register writes
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_HOLD_TICKS:    regs.hold_ticks          = cfg_data[HOLD_W-1:0];
          CFG_RAMP_INTERVAL: regs.ramp_interval_ticks = cfg_data[RAMP_W-1:0];
          CFG_DUCK_STEP:     regs.duck_step           = cfg_data[STEP_W-1:0];
          CFG_RESTORE_STEP:  regs.restore_step        = cfg_data[STEP_W-1:0];
          CFG_DUCK_FLOOR:    regs.duck_floor_q16      = cfg_data[FLOOR_W-1:0];
          default: ;
        endcase
      end
      // Compare a returned item with the oldest prediction
      if (out_valid && out_ready) begin
        if (due_updates.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, got %h",
                   $time, out_data);
          errors++;
        end else begin
          due = due_updates.pop_front();
          if (out_data.volume_write !== due.volume_write) begin
            $display("%0t: volume_write expected %0d got %0d",
                     $time, due.volume_write, out_data.volume_write);
            errors++;
          end
          if (out_data.volume !== due.volume) begin
            $display("%0t: volume expected %0d got %0d",
                     $time, due.volume, out_data.volume);
            errors++;
          end
          if (out_data.ducking_engaged !== due.ducking_engaged) begin
            $display("%0t: ducking_engaged expected %0d got %0d",
                     $time, due.ducking_engaged, out_data.ducking_engaged);
            errors++;
          end
        end
      end
      // Predict the result of an accepted item
      if (in_valid && in_ready) due_updates.push_back(duck_update(in_data));
      fail_count    <= errors;
      pending_count <= due_updates.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Bench top for the speech volume ducker: clock, reset, register phases and
// item stimulus with random idling on both sides; svd_checker does the checking.
// Depends on svd_pkg, speech_volume_ducker and svd_checker.
module testbench;
  import svd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  int                    fail_count;
  int                    pending_count;

  bit                    idling;
  int                    stall_left;
  int                    counted;

  speech_volume_ducker u_top (.*);
  svd_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Receiver side: random stall bursts on out_ready while idling is on
  always @(posedge clk) begin
    if (rst || !idling) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_item_t pkt(input logic cmd, input logic [LEVEL_W-1:0] level,
                                   input logic tgt, input logic [VOL_W-1:0] vol,
                                   input logic vld);
    in_item_t it;
    it.cmd                 = cmd;
    it.level               = level;
    it.output_is_target    = tgt;
    it.system_volume       = vol;
    it.system_volume_valid = vld;
    return it;
  endfunction

  function automatic cfg_t regs_of(input int hold, input int interval, input int dstep,
                                   input int rstep, input int floor_q16);
    cfg_t c;
    c.hold_ticks          = HOLD_W'(hold);
    c.ramp_interval_ticks = RAMP_W'(interval);
    c.duck_step           = STEP_W'(dstep);
    c.restore_step        = STEP_W'(rstep);
    c.duck_floor_q16      = FLOOR_W'(floor_q16);
    return c;
  endfunction

  // Tick with junk in the unused fields
  function automatic in_item_t make_tick();
    return pkt(CMD_TICK, LEVEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               VOL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endfunction

  // Speech packet, mostly for the headset with a readable volume
  function automatic in_item_t make_speech();
    int vol;
    vol = ($urandom_range(0, 4) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    return pkt(CMD_LEVEL, LEVEL_W'($urandom_range(0, 2)), $urandom_range(0, 9) != 0,
               VOL_W'(vol), $urandom_range(0, 9) != 0);
  endfunction

  // Non-speech packet
  function automatic in_item_t make_quiet();
    return pkt(CMD_LEVEL, LEVEL_W'($urandom_range(3, 255)), $urandom_range(0, 9) != 0,
               VOL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic in_item_t make_noise();
    return pkt(1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)), VOL_W'($urandom_range(0, 127)),
               1'($urandom_range(0, 1)));
  endfunction

  // Mostly short timers and large steps so that episodes reach the release
  function automatic cfg_t rand_regs();
    cfg_t c;
    case ($urandom_range(0, 9))
      0:       c.hold_ticks = 16'd1;
      1:       c.hold_ticks = 16'hFFFF;
      default: c.hold_ticks = HOLD_W'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 14))
      0:       c.ramp_interval_ticks = 10'd1;
      1:       c.ramp_interval_ticks = 10'd1023;
      default: c.ramp_interval_ticks = RAMP_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0:       c.duck_step = 7'd1;
      1:       c.duck_step = 7'd100;
      default: c.duck_step = STEP_W'($urandom_range(5, 60));
    endcase
    case ($urandom_range(0, 9))
      0:       c.restore_step = 7'd1;
      1:       c.restore_step = 7'd100;
      default: c.restore_step = STEP_W'($urandom_range(5, 60));
    endcase
    case ($urandom_range(0, 9))
      0:       c.duck_floor_q16 = 16'd0;
      1:       c.duck_floor_q16 = 16'hFFFF;
      default: c.duck_floor_q16 = FLOOR_W'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  // Present one item, after an occasional random gap when idling, and hold it until accepted
  task automatic send_item(input in_item_t item);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.cmd == CMD_TICK || item.output_is_target) counted++;
  endtask

  // Write all five registers back to back
  task automatic load_regs(input cfg_t c);
    cfg_write <= 1'b1;
    cfg_index <= CFG_HOLD_TICKS;
    cfg_data  <= CFG_DATA_W'(c.hold_ticks);
    @(posedge clk);
    cfg_index <= CFG_RAMP_INTERVAL;
    cfg_data  <= CFG_DATA_W'(c.ramp_interval_ticks);
    @(posedge clk);
    cfg_index <= CFG_DUCK_STEP;
    cfg_data  <= CFG_DATA_W'(c.duck_step);
    @(posedge clk);
    cfg_index <= CFG_RESTORE_STEP;
    cfg_data  <= CFG_DATA_W'(c.restore_step);
    @(posedge clk);
    cfg_index <= CFG_DUCK_FLOOR;
    cfg_data  <= CFG_DATA_W'(c.duck_floor_q16);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Drop valid and wait until every predicted item has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Talk, go quiet, then a run of ticks with the odd stray packet
  task automatic run_episode();
    int n_talk;
    int n_tick;
    n_talk = $urandom_range(1, 4);
    repeat (n_talk) begin
      send_item(make_speech());
      repeat ($urandom_range(0, 3)) send_item(make_tick());
    end
    send_item(make_quiet());
    n_tick = $urandom_range(0, 70);
    repeat (n_tick) begin
      if ($urandom_range(0, 11) == 0) send_item(make_noise());
      else send_item(make_tick());
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= CFG_HOLD_TICKS;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    idling     = 1'b1;
    counted    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset values: idle tick, ignored packets, dropped capture, saturated capture
    send_item(make_tick());
    send_item(pkt(CMD_LEVEL, 8'd255, 1'b1, 7'd50, 1'b1));
    send_item(pkt(CMD_LEVEL, 8'd0, 1'b0, 7'd50, 1'b1));
    send_item(pkt(CMD_LEVEL, 8'd2, 1'b1, 7'd0, 1'b0));
    send_item(pkt(CMD_LEVEL, 8'd2, 1'b1, 7'd127, 1'b1));
    send_item(make_tick());

    // Full-range steps: duck to zero, expire the hold, restore and release
    settle();
    load_regs(regs_of(1, 1, 100, 100, 0));
    send_item(pkt(CMD_LEVEL, 8'd0, 1'b1, 7'd10, 1'b1));
    send_item(make_tick());
    send_item(pkt(CMD_LEVEL, 8'd3, 1'b1, 7'd10, 1'b1));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_tick());

    // Release while the hold still runs, then let the hold expire with no baseline
    settle();
    load_regs(regs_of(3, 0, 0, 0, 65535));
    send_item(pkt(CMD_LEVEL, 8'd1, 1'b1, 7'd64, 1'b1));
    send_item(pkt(CMD_LEVEL, 8'd200, 1'b1, 7'd64, 1'b1));
    send_item(make_tick());
    send_item(make_tick());
    send_item(make_tick());

    // Zero hold and zero steps: the ramp rewrites the same volume
    settle();
    load_regs(regs_of(0, 1, 0, 0, 32768));
    send_item(pkt(CMD_LEVEL, 8'd1, 1'b1, 7'd64, 1'b1));
    send_item(make_tick());
    send_item(pkt(CMD_LEVEL, 8'd3, 1'b1, 7'd64, 1'b1));
    send_item(make_tick());

    // Largest timers, smallest steps and floor
    settle();
    load_regs(regs_of(65535, 1023, 1, 1, 1));
    send_item(pkt(CMD_LEVEL, 8'd0, 1'b1, 7'd100, 1'b1));
    send_item(pkt(CMD_LEVEL, 8'd255, 1'b1, 7'd100, 1'b1));
    send_item(make_tick());
    send_item(make_tick());

    // Random phases, each with its own register setting; no idling in the last
    counted = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_regs(rand_regs());
      idling = (ph != PHASES - 1);
      while (counted < (ph + 1) * RANDOM_ITEMS / PHASES) run_episode();
    end

    settle();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/svd_pkg.sv
design/svd_cfg.sv
design/svd_core.sv
design/speech_volume_ducker.sv
tb/svd_checker.sv
tb/testbench.sv
